// ===== rtl/status_led_color_controller_unit_assert.svh =====
`ifndef STATUS_LED_COLOR_CONTROLLER_UNIT_ASSERT_SVH
`define STATUS_LED_COLOR_CONTROLLER_UNIT_ASSERT_SVH

// condition that must hold on every clock edge out of reset
`define SLCC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition on one edge that forces a consequence on the next edge
`define SLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/slcc_pkg.sv =====
package slcc_pkg;

    // one tick of status input
    typedef struct packed {
        logic        armed;
        logic [3:0]  online_mask;
        logic [31:0] now_us;
        logic        kill_switch;
        logic        battery_fault_event;
        logic        battery_low_event;
        logic        mag_fault_event;
        logic        detector_fault_event;
        logic        arming_high_event;
    } slcc_in_t;

    // one led update result
    typedef struct packed {
        logic       send_valid;
        logic [2:0] led_number;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } slcc_out_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // channel level before brightness scaling
    typedef enum logic [1:0] {
        LVL_OFF,
        LVL_FULL,
        LVL_HALF,
        LVL_GRAY
    } level_t;

    typedef struct packed {
        level_t r;
        level_t g;
        level_t b;
    } levels_t;

    // color codes
    localparam logic [3:0] COLOR_OFF    = 4'd0;
    localparam logic [3:0] COLOR_RED    = 4'd1;
    localparam logic [3:0] COLOR_ORANGE = 4'd2;
    localparam logic [3:0] COLOR_YELLOW = 4'd3;
    localparam logic [3:0] COLOR_GREEN  = 4'd4;
    localparam logic [3:0] COLOR_CYAN   = 4'd5;
    localparam logic [3:0] COLOR_BLUE   = 4'd6;
    localparam logic [3:0] COLOR_PURPLE = 4'd7;
    localparam logic [3:0] COLOR_WHITE  = 4'd8;
    localparam logic [3:0] COLOR_WHEEL  = 4'd9;

    // register indexes
    localparam logic [2:0] REG_LED0_COLOR  = 3'd0;
    localparam logic [2:0] REG_LED1_COLOR  = 3'd1;
    localparam logic [2:0] REG_LED2_COLOR  = 3'd2;
    localparam logic [2:0] REG_LED3_COLOR  = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS  = 3'd4;
    localparam logic [2:0] REG_FAST_PERIOD = 3'd5;
    localparam logic [2:0] REG_SLOW_PERIOD = 3'd6;

    // reset values and fixed scale factors
    localparam logic [9:0]  BRIGHT_RESET      = 10'd256;
    localparam logic [8:0]  EFF_MAX           = 9'd256;
    localparam logic [8:0]  EFF_DIS_RESET     = 9'd87;
    localparam logic [7:0]  DISARMED_SCALE    = 8'd87;
    localparam logic [23:0] FAST_RESET        = 24'd100000;
    localparam logic [23:0] SLOW_RESET        = 24'd500000;
    localparam logic [9:0]  SCALE_FULL        = 10'd765;
    localparam logic [9:0]  SCALE_HALF        = 10'd384;
    localparam logic [9:0]  SCALE_GRAY        = 10'd300;
    localparam logic [15:0] WHEEL_SEG1_END    = 16'd255;
    localparam logic [15:0] WHEEL_SEG2_END    = 16'd510;
    localparam logic [15:0] WHEEL_SEG3_END    = 16'd765;
    localparam logic [4:0]  STICKY_FAST_MASK  = 5'b11101;
    localparam int          STICKY_LOW_BIT    = 1;

    // color code to channel levels
    function automatic levels_t color_levels(input logic [3:0] code);
        levels_t lv;
        lv = '{LVL_OFF, LVL_OFF, LVL_OFF};
        unique case (code)
            COLOR_OFF:    lv = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
            COLOR_RED:    lv = '{LVL_FULL, LVL_OFF,  LVL_OFF};
            COLOR_ORANGE: lv = '{LVL_FULL, LVL_HALF, LVL_OFF};
            COLOR_YELLOW: lv = '{LVL_FULL, LVL_FULL, LVL_OFF};
            COLOR_GREEN:  lv = '{LVL_OFF,  LVL_FULL, LVL_OFF};
            COLOR_CYAN:   lv = '{LVL_OFF,  LVL_FULL, LVL_FULL};
            COLOR_BLUE:   lv = '{LVL_OFF,  LVL_OFF,  LVL_FULL};
            COLOR_PURPLE: lv = '{LVL_FULL, LVL_OFF,  LVL_FULL};
            COLOR_WHITE:  lv = '{LVL_FULL, LVL_FULL, LVL_FULL};
            COLOR_WHEEL:  lv = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
            default:      lv = '{LVL_GRAY, LVL_GRAY, LVL_GRAY};
        endcase
        return lv;
    endfunction

endpackage

// ===== rtl/slcc_if.sv =====
// status tick channel
interface slcc_in_if;
    import slcc_pkg::*;

    logic     valid;
    logic     ready;
    slcc_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// led update channel
interface slcc_out_if;
    import slcc_pkg::*;

    logic      valid;
    logic      ready;
    slcc_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/status_led_color_controller_unit.sv =====
// channel   | direction | transfer
// ----------+-----------+------------------------------------------------
// in_ch     | in        | one status tick (armed, online, time, events)
// out_ch    | out       | one result per tick (send_valid, led, rgb)
// apb       | in/out    | color, brightness and blink period registers
//
// each tick passes through the input register and then the result register
// the input register takes a new tick every cycle while the result is consumed
// a stalled result holds the tick in the input register; led state updates
// only when the tick moves on into the result register
// async active low reset; no clearing pass, all state is in flip-flops
module status_led_color_controller_unit #(
    parameter int LED_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    slcc_in_if.sink     in_ch,
    slcc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import slcc_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);

    // configuration registers
    logic [3:0]  color_reg [4];
    logic [9:0]  brightness_reg;
    logic [8:0]  eff_full_reg;
    logic [8:0]  eff_dis_reg;
    logic [23:0] fast_period_reg;
    logic [23:0] slow_period_reg;

    // pipeline registers
    logic      s1_valid_reg;
    slcc_in_t  s1_item_reg;
    logic      out_valid_reg;
    slcc_out_t out_item_reg;

    // display state
    rgb_t                 led_rgb_reg [LED_COUNT];
    logic [LED_COUNT-1:0] sent_reg;
    logic [4:0]           sticky_reg;
    logic                 blink_on_reg;
    logic [31:0]          last_blink_reg;
    logic [15:0]          wheel_cnt_reg;
    logic [IDX_W-1:0]     wheel_idx_reg;

    rgb_t                 led_rgb_next [LED_COUNT];
    logic [LED_COUNT-1:0] sent_next;
    logic [4:0]           sticky_next;
    logic                 blink_on_next;
    logic [31:0]          last_blink_next;
    logic [15:0]          wheel_cnt_next;
    logic [IDX_W-1:0]     wheel_idx_next;
    slcc_out_t            result;

    logic cfg_write;
    logic out_free;
    logic s1_adv;
    logic in_xfer;

    // handshake
    assign out_free     = !out_valid_reg || out_ch.ready;
    assign s1_adv       = s1_valid_reg && out_free;
    assign in_ch.ready  = !s1_valid_reg || out_free;
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

    // apb write, with brightness scale factors precomputed
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    logic [16:0] dis_prod;
    logic [8:0]  dis_eff;
    assign dis_prod = 17'(pwdata[9:0]) * 17'(DISARMED_SCALE);
    assign dis_eff  = dis_prod[16:8];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) begin
                color_reg[i] <= COLOR_OFF;
            end
            brightness_reg  <= BRIGHT_RESET;
            eff_full_reg    <= EFF_MAX;
            eff_dis_reg     <= EFF_DIS_RESET;
            fast_period_reg <= FAST_RESET;
            slow_period_reg <= SLOW_RESET;
        end
        else if (cfg_write) begin
            unique case (paddr[4:2])
                REG_LED0_COLOR: color_reg[0] <= pwdata[3:0];
                REG_LED1_COLOR: color_reg[1] <= pwdata[3:0];
                REG_LED2_COLOR: color_reg[2] <= pwdata[3:0];
                REG_LED3_COLOR: color_reg[3] <= pwdata[3:0];
                REG_BRIGHTNESS:
                begin
                    brightness_reg <= pwdata[9:0];
                    eff_full_reg   <= (pwdata[9:0] > 10'(EFF_MAX)) ? EFF_MAX : pwdata[8:0];
                    eff_dis_reg    <= (dis_eff > EFF_MAX) ? EFF_MAX : dis_eff;
                end
                REG_FAST_PERIOD: fast_period_reg <= pwdata[23:0];
                REG_SLOW_PERIOD: slow_period_reg <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // apb read
    always_comb begin
        unique case (paddr[4:2])
            REG_LED0_COLOR:  prdata = 32'(color_reg[0]);
            REG_LED1_COLOR:  prdata = 32'(color_reg[1]);
            REG_LED2_COLOR:  prdata = 32'(color_reg[2]);
            REG_LED3_COLOR:  prdata = 32'(color_reg[3]);
            REG_BRIGHTNESS:  prdata = 32'(brightness_reg);
            REG_FAST_PERIOD: prdata = 32'(fast_period_reg);
            REG_SLOW_PERIOD: prdata = 32'(slow_period_reg);
            default:         prdata = '0;
        endcase
    end

    // one tick of display logic
    always_comb begin
        logic [4:0]           sticky;
        logic                 disarmed;
        logic                 fast;
        logic                 slow;
        logic [23:0]          period;
        logic [31:0]          elapsed;
        logic                 toggle;
        logic                 blinking;
        logic                 show;
        logic                 blank;
        logic [8:0]           eff;
        logic [17:0]          prod_full;
        logic [17:0]          prod_half;
        logic [17:0]          prod_gray;
        logic [7:0]           ch_full;
        logic [7:0]           ch_half;
        logic [7:0]           ch_gray;
        logic [15:0]          c;
        rgb_t                 wheel_rgb;
        logic                 wheel_zero;
        logic [3:0]           code;
        levels_t              lv;
        logic [LED_COUNT-1:0] online;
        logic [LED_COUNT-1:0] changed;
        logic [LED_COUNT-1:0] sent_mid;
        logic [LED_COUNT-1:0] pending;
        logic [LED_COUNT-1:0] sel_bit;
        logic                 found;
        logic [3:0]           sel_num;
        rgb_t                 sel_rgb;
        logic [15:0]          c_mid;
        logic [IDX_W-1:0]     idx_mid;

        // sticky events and mode
        sticky = sticky_reg | {s1_item_reg.arming_high_event,
                               s1_item_reg.detector_fault_event,
                               s1_item_reg.mag_fault_event,
                               s1_item_reg.battery_low_event,
                               s1_item_reg.battery_fault_event};
        disarmed = !s1_item_reg.armed;
        fast     = s1_item_reg.kill_switch || ((sticky & STICKY_FAST_MASK) != '0);
        slow     = !fast && sticky[STICKY_LOW_BIT];
        blinking = !disarmed && (fast || slow);

        // blink timer
        period  = fast ? fast_period_reg : slow_period_reg;
        elapsed = s1_item_reg.now_us - last_blink_reg;
        toggle  = blinking && (elapsed > 32'(period));
        show    = !blinking || (toggle && !blink_on_reg);
        blank   = toggle && blink_on_reg;

        // channel values for the three levels
        eff       = disarmed ? eff_dis_reg : eff_full_reg;
        prod_full = 18'(eff) * 18'(SCALE_FULL);
        prod_half = 18'(eff) * 18'(SCALE_HALF);
        prod_gray = 18'(eff) * 18'(SCALE_GRAY);
        ch_full   = prod_full[17:10];
        ch_half   = prod_half[17:10];
        ch_gray   = prod_gray[17:10];

        // rgb wheel
        c = wheel_cnt_reg;
        if (c <= WHEEL_SEG1_END) begin
            wheel_rgb = '{c[7:0], 8'd0, 8'(WHEEL_SEG1_END - c)};
        end
        else if (c <= WHEEL_SEG2_END) begin
            wheel_rgb = '{8'(WHEEL_SEG2_END - c), 8'(c - WHEEL_SEG1_END), 8'd0};
        end
        else begin
            wheel_rgb = '{8'd0, 8'(WHEEL_SEG3_END - c), 8'(c - WHEEL_SEG2_END)};
        end
        wheel_zero = 1'b0;

        // per led update
        for (int i = 0; i < LED_COUNT; i++) begin
            code            = (i < 4) ? color_reg[2'(i)] : COLOR_OFF;
            lv              = color_levels(code);
            led_rgb_next[i] = led_rgb_reg[i];
            if (blank) begin
                led_rgb_next[i] = '0;
            end
            else if (show) begin
                if (code == COLOR_WHEEL) begin
                    if (wheel_idx_reg == IDX_W'(i)) begin
                        if (c <= WHEEL_SEG3_END) begin
                            led_rgb_next[i] = wheel_rgb;
                        end
                        else begin
                            wheel_zero = 1'b1;
                        end
                    end
                end
                else begin
                    led_rgb_next[i].r = (lv.r == LVL_FULL) ? ch_full :
                                        (lv.r == LVL_HALF) ? ch_half :
                                        (lv.r == LVL_GRAY) ? ch_gray : 8'd0;
                    led_rgb_next[i].g = (lv.g == LVL_FULL) ? ch_full :
                                        (lv.g == LVL_HALF) ? ch_half :
                                        (lv.g == LVL_GRAY) ? ch_gray : 8'd0;
                    led_rgb_next[i].b = (lv.b == LVL_FULL) ? ch_full :
                                        (lv.b == LVL_HALF) ? ch_half :
                                        (lv.b == LVL_GRAY) ? ch_gray : 8'd0;
                end
            end
            changed[i] = (led_rgb_next[i] != led_rgb_reg[i]);
            online[i]  = (i < 4) ? s1_item_reg.online_mask[2'(i)] : 1'b0;
        end

        // lowest dirty online led
        sent_mid = sent_reg & ~changed;
        pending  = ~sent_mid & online;
        found    = 1'b0;
        sel_num  = '0;
        sel_rgb  = '0;
        sel_bit  = '0;
        for (int i = LED_COUNT - 1; i >= 0; i--) begin
            if (pending[i]) begin
                found      = 1'b1;
                sel_num    = 4'(i);
                sel_rgb    = led_rgb_next[i];
                sel_bit    = '0;
                sel_bit[i] = 1'b1;
            end
        end
        sent_next = sent_mid | sel_bit;

        result.send_valid = found;
        result.led_number = found ? 3'(sel_num + 4'd1) : 3'd0;
        result.red        = sel_rgb.r;
        result.green      = sel_rgb.g;
        result.blue       = sel_rgb.b;

        // wheel counter and its led index
        c_mid          = wheel_zero ? 16'd0 : c;
        idx_mid        = wheel_zero ? '0 : wheel_idx_reg;
        wheel_cnt_next = c_mid + 16'd1;
        if (c_mid == 16'hFFFF || idx_mid == IDX_LAST) begin
            wheel_idx_next = '0;
        end
        else begin
            wheel_idx_next = idx_mid + IDX_W'(1);
        end

        sticky_next     = disarmed ? 5'd0 : sticky;
        blink_on_next   = toggle ? !blink_on_reg : blink_on_reg;
        last_blink_next = toggle ? s1_item_reg.now_us : last_blink_reg;
    end

    // pipeline control and state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                led_rgb_reg[i] <= '0;
            end
            sent_reg       <= '0;
            sticky_reg     <= '0;
            blink_on_reg   <= 1'b0;
            last_blink_reg <= '0;
            wheel_cnt_reg  <= '0;
            wheel_idx_reg  <= '0;
        end
        else begin
            if (in_xfer) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                for (int i = 0; i < LED_COUNT; i++) begin
                    led_rgb_reg[i] <= led_rgb_next[i];
                end
                sent_reg       <= sent_next;
                sticky_reg     <= sticky_next;
                blink_on_reg   <= blink_on_next;
                last_blink_reg <= last_blink_next;
                wheel_cnt_reg  <= wheel_cnt_next;
                wheel_idx_reg  <= wheel_idx_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        if (in_xfer) begin
            s1_item_reg <= in_ch.payload;
        end
        if (s1_adv) begin
            out_item_reg <= result;
        end
    end

    // checks
`include "status_led_color_controller_unit_assert.svh"

    `SLCC_ASSERT_NEXT(a_adv_gives_result, s1_adv, out_valid_reg, "tick advanced without result")
    `SLCC_ASSERT_NEXT(a_stall_holds_state, s1_valid_reg && !s1_adv,
        $stable(sent_reg) && $stable(wheel_cnt_reg) && $stable(sticky_reg),
        "display state moved during stall")
    `SLCC_ASSERT_NEXT(a_disarmed_clears_sticky, s1_adv && !s1_item_reg.armed,
        sticky_reg == 5'd0, "sticky flags kept while disarmed")
    `SLCC_ASSERT_ALWAYS(a_wheel_idx_range, wheel_idx_reg <= IDX_LAST,
        "wheel index out of range")

endmodule
